// ===== rtl/core/pgp_pkg.sv =====
// shared types, widths, register indexes and partial product helpers for ground plane mapping
package pgp_pkg;

    localparam int PIX_W = 16;
    localparam int CFG_W = 32;
    localparam int IDX_W = 3;
    localparam int M_W   = 49;
    localparam int B_W   = 34;
    localparam int H_W   = 25;
    localparam int OP_W  = 2 * H_W;
    localparam int PP_W  = 2 * OP_W;
    localparam int DET_W = 98;
    localparam int NUM_W = 82;
    localparam int RND_SH = 21;
    localparam int D_W   = DET_W;
    localparam int N_W   = NUM_W - 1 + RND_SH + 1;
    localparam int Q_W   = 33;
    localparam int R_W   = D_W + Q_W;
    localparam int DIV_NS = Q_W + 1;

    localparam logic [IDX_W-1:0] CFG_ROW0_COL0 = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ROW0_COL1 = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ROW1_COL0 = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ROW1_COL1 = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SLOPE_X   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SLOPE_Y   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_OFFSET_H  = 3'd6;
    localparam logic [IDX_W-1:0] CFG_OFFSET_V  = 3'd7;

    localparam logic [CFG_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [OP_W-1:0]          ll;
        logic signed [OP_W:0]     lh;
        logic signed [OP_W:0]     hl;
        logic signed [OP_W-1:0]   hh;
    } t_pp;

    typedef struct packed {
        logic singular;
        logic neg_x;
        logic neg_y;
    } t_side;

    typedef struct packed {
        logic [N_W-1:0] n_x;
        logic [N_W-1:0] n_y;
        logic [D_W-1:0] d;
        t_side          side;
    } t_div_in;

    typedef struct packed {
        logic [Q_W-1:0] q_x;
        logic [Q_W-1:0] q_y;
        logic           ov_x;
        logic           ov_y;
        t_side          side;
    } t_div_out;

    // four partial products of two signed operands, each under 26x26 bits
    function automatic t_pp pp_make(input logic signed [OP_W-1:0] a,
                                    input logic signed [OP_W-1:0] b);
        t_pp r;
        logic [H_W-1:0]        lo_a;
        logic [H_W-1:0]        lo_b;
        logic signed [H_W-1:0] hi_a;
        logic signed [H_W-1:0] hi_b;
        lo_a = a[H_W-1:0];
        lo_b = b[H_W-1:0];
        hi_a = a[OP_W-1:H_W];
        hi_b = b[OP_W-1:H_W];
        r.ll = OP_W'(lo_a) * OP_W'(lo_b);
        r.lh = (OP_W+1)'($signed({1'b0, lo_a})) * (OP_W+1)'(hi_b);
        r.hl = (OP_W+1)'(hi_a) * (OP_W+1)'($signed({1'b0, lo_b}));
        r.hh = OP_W'(hi_a) * OP_W'(hi_b);
        return r;
    endfunction

    function automatic logic signed [PP_W-1:0] pp_sum(input t_pp p);
        logic signed [PP_W-1:0] t_low;
        logic signed [PP_W-1:0] t_mid;
        logic signed [PP_W-1:0] t_high;
        t_low  = $signed({{(PP_W-OP_W){1'b0}}, p.ll});
        t_mid  = (PP_W'(p.lh) + PP_W'(p.hl)) <<< H_W;
        t_high = PP_W'(p.hh) <<< OP_W;
        return t_low + t_mid + t_high;
    endfunction

endpackage

// ===== rtl/core/pixel_to_ground_plane.sv =====
// top level: maps an image pixel onto the ground plane z=0 by cramer's rule
//
// one transaction per clock cycle sustained while i_stall stays low; the path holds
// 41 register stages, and each pixel passes through all of them in order before its
// result leaves the output register with o_valid high: six arithmetic
// stages (coordinate products, matrix entries, split 25-bit partial products,
// product sums, determinant and numerators, magnitudes), 34 divider stages
// (overflow check then one quotient bit per stage for both coordinates with a
// shared denominator) and the output register. the pipeline collapses bubbles,
// so input is still taken while a finished result waits as long as some stage
// is empty. coordinates are rounded to nearest (ties away from zero) and
// clipped to signed q16.16 with o_saturated set; a zero determinant returns
// zeros with o_singular set.
// configuration writes are only legal while the pipeline is empty.
module pixel_to_ground_plane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pgp_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [pgp_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pgp_pkg::PIX_W-1:0]         i_pixel_x,
    input  logic [pgp_pkg::PIX_W-1:0]         i_pixel_y,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [pgp_pkg::CFG_W-1:0]  o_world_x,
    output logic signed [pgp_pkg::CFG_W-1:0]  o_world_y,
    output logic                              o_singular,
    output logic                              o_saturated
);
    import pgp_pkg::*;

    // configuration registers
    logic signed [CFG_W-1:0] r_a00, r_a01, r_a10, r_a11;
    logic signed [CFG_W-1:0] r_sx, r_sy, r_ou, r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a00 <= '0;
            r_a01 <= '0;
            r_a10 <= '0;
            r_a11 <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_ou  <= '0;
            r_ov  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW0_COL0: r_a00 <= i_cfg_data;
                CFG_ROW0_COL1: r_a01 <= i_cfg_data;
                CFG_ROW1_COL0: r_a10 <= i_cfg_data;
                CFG_ROW1_COL1: r_a11 <= i_cfg_data;
                CFG_SLOPE_X:   r_sx  <= i_cfg_data;
                CFG_SLOPE_Y:   r_sy  <= i_cfg_data;
                CFG_OFFSET_H:  r_ou  <= i_cfg_data;
                CFG_OFFSET_V:  r_ov  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid bits and the bubble-collapsing enable chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_vo;
    logic e1, e2, e3, e4, e5, e6, e_out;
    logic div_stall;
    logic div_valid;

    assign e_out = !r_vo || !i_stall;
    assign e6    = !r_v6 || !div_stall;
    assign e5    = !r_v5 || e6;
    assign e4    = !r_v4 || e5;
    assign e3    = !r_v3 || e4;
    assign e2    = !r_v2 || e3;
    assign e1    = !r_v1 || e2;
    assign o_stall = !e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (e1)    r_v1 <= i_valid;
            if (e2)    r_v2 <= r_v1;
            if (e3)    r_v3 <= r_v2;
            if (e4)    r_v4 <= r_v3;
            if (e5)    r_v5 <= r_v4;
            if (e6)    r_v6 <= r_v5;
            if (e_out) r_vo <= div_valid;
        end
    end

    // stage 1: slope times pixel coordinate, right-hand side
    logic signed [M_W-1:0] r1_pxu, r1_pyu, r1_pxv, r1_pyv;
    logic signed [B_W-1:0] r1_b0, r1_b1;
    logic signed [M_W-1:0] u_s, v_s;

    assign u_s = M_W'($signed({1'b0, i_pixel_x}));
    assign v_s = M_W'($signed({1'b0, i_pixel_y}));

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_pxu <= M_W'(r_sx) * u_s;
            r1_pyu <= M_W'(r_sy) * u_s;
            r1_pxv <= M_W'(r_sx) * v_s;
            r1_pyv <= M_W'(r_sy) * v_s;
            // pixel q12.4 lifted to q16.16
            r1_b0  <= $signed({6'd0, i_pixel_x, 12'd0}) - B_W'(r_ou);
            r1_b1  <= $signed({6'd0, i_pixel_y, 12'd0}) - B_W'(r_ov);
        end
    end

    // stage 2: matrix entries in q.20
    logic signed [M_W-1:0] r2_m00, r2_m01, r2_m10, r2_m11;
    logic signed [B_W-1:0] r2_b0, r2_b1;

    always_ff @(posedge i_clk) begin
        if (e2) begin
            r2_m00 <= (M_W'(r_a00) <<< 4) - r1_pxu;
            r2_m01 <= (M_W'(r_a01) <<< 4) - r1_pyu;
            r2_m10 <= (M_W'(r_a10) <<< 4) - r1_pxv;
            r2_m11 <= (M_W'(r_a11) <<< 4) - r1_pyv;
            r2_b0  <= r1_b0;
            r2_b1  <= r1_b1;
        end
    end

    // stage 3: partial products of the six cross terms
    t_pp r3_pp [6];

    always_ff @(posedge i_clk) begin
        if (e3) begin
            r3_pp[0] <= pp_make(OP_W'(r2_m00), OP_W'(r2_m11));
            r3_pp[1] <= pp_make(OP_W'(r2_m01), OP_W'(r2_m10));
            r3_pp[2] <= pp_make(OP_W'(r2_b0),  OP_W'(r2_m11));
            r3_pp[3] <= pp_make(OP_W'(r2_m01), OP_W'(r2_b1));
            r3_pp[4] <= pp_make(OP_W'(r2_m00), OP_W'(r2_b1));
            r3_pp[5] <= pp_make(OP_W'(r2_m10), OP_W'(r2_b0));
        end
    end

    // stage 4: full products
    logic signed [PP_W-1:0] r4_p [6];

    always_ff @(posedge i_clk) begin
        if (e4) begin
            for (int k = 0; k < 6; k++) begin
                r4_p[k] <= pp_sum(r3_pp[k]);
            end
        end
    end

    // stage 5: determinant and cramer numerators, exact
    logic signed [DET_W-1:0] r5_det;
    logic signed [NUM_W-1:0] r5_nx, r5_ny;
    logic signed [PP_W-1:0]  det_w, nx_w, ny_w;

    assign det_w = r4_p[0] - r4_p[1];
    assign nx_w  = r4_p[2] - r4_p[3];
    assign ny_w  = r4_p[4] - r4_p[5];

    always_ff @(posedge i_clk) begin
        if (e5) begin
            r5_det <= det_w[DET_W-1:0];
            r5_nx  <= nx_w[NUM_W-1:0];
            r5_ny  <= ny_w[NUM_W-1:0];
        end
    end

    // stage 6: dividend 2*|num|*2^20 + |det| and divisor 2*|det|
    t_div_in          r6_div;
    logic [DET_W-1:0] abs_det;
    logic [NUM_W-1:0] abs_nx, abs_ny;

    assign abs_det = r5_det[DET_W-1] ? DET_W'(-r5_det) : DET_W'(r5_det);
    assign abs_nx  = r5_nx[NUM_W-1] ? NUM_W'(-r5_nx) : NUM_W'(r5_nx);
    assign abs_ny  = r5_ny[NUM_W-1] ? NUM_W'(-r5_ny) : NUM_W'(r5_ny);

    always_ff @(posedge i_clk) begin
        if (e6) begin
            r6_div.n_x <= N_W'({abs_nx[NUM_W-2:0], {RND_SH{1'b0}}}) + N_W'(abs_det);
            r6_div.n_y <= N_W'({abs_ny[NUM_W-2:0], {RND_SH{1'b0}}}) + N_W'(abs_det);
            r6_div.d   <= {abs_det[DET_W-2:0], 1'b0};
            r6_div.side.singular <= (r5_det == '0);
            r6_div.side.neg_x    <= r5_nx[NUM_W-1] ^ r5_det[DET_W-1];
            r6_div.side.neg_y    <= r5_ny[NUM_W-1] ^ r5_det[DET_W-1];
        end
    end

    t_div_out div_out;

    pgp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .o_stall (div_stall),
        .i_data  (r6_div),
        .o_valid (div_valid),
        .i_stall (!e_out),
        .o_data  (div_out)
    );

    // sign, clip to q16.16 and force zeros for a singular system
    logic [CFG_W-1:0] wx, wy;
    logic             sat_x, sat_y;

    always_comb begin
        if (div_out.side.neg_x) begin
            sat_x = div_out.ov_x || (div_out.q_x > Q_W'(NEG_MIN));
            wx    = sat_x ? NEG_MIN : (~div_out.q_x[CFG_W-1:0] + 32'd1);
        end else begin
            sat_x = div_out.ov_x || (div_out.q_x > Q_W'(POS_MAX));
            wx    = sat_x ? POS_MAX : div_out.q_x[CFG_W-1:0];
        end
        if (div_out.side.neg_y) begin
            sat_y = div_out.ov_y || (div_out.q_y > Q_W'(NEG_MIN));
            wy    = sat_y ? NEG_MIN : (~div_out.q_y[CFG_W-1:0] + 32'd1);
        end else begin
            sat_y = div_out.ov_y || (div_out.q_y > Q_W'(POS_MAX));
            wy    = sat_y ? POS_MAX : div_out.q_y[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_out) begin
            o_singular <= div_out.side.singular;
            if (div_out.side.singular) begin
                o_world_x   <= '0;
                o_world_y   <= '0;
                o_saturated <= 1'b0;
            end else begin
                o_world_x   <= wx;
                o_world_y   <= wy;
                o_saturated <= sat_x || sat_y;
            end
        end
    end

    assign o_valid = r_vo;

    // a singular result carries zeros and no clipping
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_world_x == '0 && o_world_y == '0 && !o_saturated)
        else $error("singular result not zeroed");

    // a clipped result shows a bound in one coordinate
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_world_x == POS_MAX || o_world_x == NEG_MIN ||
            o_world_y == POS_MAX || o_world_y == NEG_MIN)
        else $error("saturated flag without a bound value");

    // input is held off only when the first stage and the one behind it are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v1 && r_v2)
        else $error("input stalled with free first stages");

    // a held output transaction keeps its result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_world_x) && $stable(o_world_y))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/pgp_divider.sv =====
// pipelined restoring divider, one quotient bit per stage for both coordinates
module pgp_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pgp_pkg::t_div_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output pgp_pkg::t_div_out o_data
);
    import pgp_pkg::*;

    typedef struct packed {
        logic [N_W-1:0] rem_x;
        logic [N_W-1:0] rem_y;
        logic [D_W-1:0] d;
        logic [Q_W-1:0] q_x;
        logic [Q_W-1:0] q_y;
        logic           ov_x;
        logic           ov_y;
        t_side          side;
    } t_st;

    t_st               r_st [DIV_NS];
    t_st               n_st [DIV_NS];
    logic [DIV_NS-1:0] r_vld;
    logic [DIV_NS:0]   en;

    function automatic t_st div_step(input t_st s, input int sh);
        t_st            r;
        logic [R_W-1:0] dd;
        logic           ge_x;
        logic           ge_y;
        r    = s;
        dd   = R_W'(s.d) << sh;
        ge_x = R_W'(s.rem_x) >= dd;
        ge_y = R_W'(s.rem_y) >= dd;
        if (ge_x) begin
            r.rem_x = s.rem_x - dd[N_W-1:0];
        end
        if (ge_y) begin
            r.rem_y = s.rem_y - dd[N_W-1:0];
        end
        r.q_x = {s.q_x[Q_W-2:0], ge_x};
        r.q_y = {s.q_y[Q_W-2:0], ge_y};
        return r;
    endfunction

    // stall ripples back only through occupied stages
    assign en[DIV_NS] = !i_stall;
    genvar g;
    generate
        for (g = 0; g < DIV_NS; g++) begin : g_en
            assign en[g] = !r_vld[g] || en[g+1];
        end
    endgenerate

    always_comb begin
        logic [R_W-1:0] top;
        top           = R_W'(i_data.d) << Q_W;
        n_st[0].rem_x = i_data.n_x;
        n_st[0].rem_y = i_data.n_y;
        n_st[0].d     = i_data.d;
        n_st[0].q_x   = '0;
        n_st[0].q_y   = '0;
        n_st[0].ov_x  = R_W'(i_data.n_x) >= top;
        n_st[0].ov_y  = R_W'(i_data.n_y) >= top;
        n_st[0].side  = i_data.side;
        for (int k = 1; k < DIV_NS; k++) begin
            n_st[k] = div_step(r_st[k-1], Q_W - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < DIV_NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_NS; k++) begin
            if (en[k]) r_st[k] <= n_st[k];
        end
    end

    assign o_stall     = !en[0];
    assign o_valid     = r_vld[DIV_NS-1];
    assign o_data.q_x  = r_st[DIV_NS-1].q_x;
    assign o_data.q_y  = r_st[DIV_NS-1].q_y;
    assign o_data.ov_x = r_st[DIV_NS-1].ov_x;
    assign o_data.ov_y = r_st[DIV_NS-1].ov_y;
    assign o_data.side = r_st[DIV_NS-1].side;

endmodule
